@@ sv/frx_pkg.sv @@
// Shared types, codes and constants of the ring frame extractor.
`timescale 1ns / 1ps
package frx_pkg;

  // input op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_POLL  = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REWIND  = 1'b1;

  localparam logic [7:0]  EMPTY_SLOT    = 8'd255;
  localparam logic [7:0]  HEADER_BASE   = 8'd250;
  localparam logic [15:0] COUNT_LIMIT   = 16'd65500;
  localparam logic [15:0] PAYLOAD_RESET = 16'h3200;
  localparam logic [2:0]  NODE_ID_RESET = 3'd0;
  localparam logic [5:0]  REWIND_RESET  = 6'd10;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } frx_in_t;

  typedef struct packed {
    logic [15:0] payload;
    logic [15:0] stall_count;
    logic [15:0] overrun_count;
  } frx_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_SCAN,
    ST_FRAME,
    ST_FINISH
  } frx_state_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c >= COUNT_LIMIT) ? COUNT_LIMIT : c + 16'd1;
  endfunction

endpackage

@@ sv/frx_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ring_frame_extractor.sv @@
// Ring frame extractor top level: byte ring, poll sequencer and counters.
// Write beat: stored in the ring while idle; the next beat is taken in the following cycle.
// Poll beat: decide, then check and scan slots outside a frame (header included), read the
//   frame bytes and finish; one ring read per cycle from a RAM with registered read data.
// Result sits in an output register; a new poll may finish only once it is free.
// Reset (rst, synchronous) clears positions, counters and the per-slot valid bits and loads
//   the config reset values; an invalid slot reads as empty, so no clearing pass.
`timescale 1ns / 1ps
module ring_frame_extractor #(
  parameter int RING_DEPTH  = 64,
  parameter int FRAME_BYTES = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input beats
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  frx_pkg::frx_in_t                     in_data,
  // result beats
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output frx_pkg::frx_out_t                    out_data,
  // configuration writes
  input  logic                                 cfg_wr_en,
  input  logic [frx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frx_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [PW:0]   DEPTH_EXT  = (PW + 1)'(RING_DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(RING_DEPTH - 1);
  localparam logic [PW:0]   HALF_DEPTH = (PW + 1)'(RING_DEPTH / 2);
  localparam logic [FW-1:0] LAST_BYTE  = FW'(FRAME_BYTES - 1);
  localparam logic [PW-1:0] BACK_RESET =
    PW'(int'(frx_pkg::REWIND_RESET) % RING_DEPTH);

  // ---------------------------------------------------------------------------
  // Position arithmetic, all modulo RING_DEPTH (which need not be a power of 2)
  // ---------------------------------------------------------------------------
  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  // distance from r forward to w
  function automatic logic [PW-1:0] gap(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (d[PW]) begin
      d = d + DEPTH_EXT;
    end
    return d[PW-1:0];
  endfunction

  // rewind distance reduced modulo the ring depth; at most 8 subtracts, enough for 6 bits on a depth of 8 or more
  function automatic logic [PW-1:0] wrap_back(input logic [5:0] v);
    logic [8:0] t;
    t = {3'b0, v};
    for (int k = 0; k < 8; k++) begin
      if (t >= 9'(RING_DEPTH)) begin
        t = t - 9'(RING_DEPTH);
      end
    end
    return t[PW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  frx_pkg::frx_state_t state, state_next;

  logic [2:0]              node_id;
  logic [5:0]              rewind_distance;
  logic [PW-1:0]           rewind_back;      // rewind_distance mod depth, kept at write

  logic [PW-1:0]           wp, wp_next;      // write position
  logic [PW-1:0]           rp, rp_next;      // saved read position
  logic [PW-1:0]           prior_wp, prior_wp_next;
  logic [PW-1:0]           rd, rd_next;      // working reader during a poll
  logic [FW-1:0]           cnt, cnt_next;    // frame byte index
  logic [15:0]             held, held_next;
  logic [15:0]             stalls, stalls_next;
  logic [15:0]             overruns, overruns_next;
  logic [RING_DEPTH-1:0]   slot_valid, slot_valid_next;
  logic                    out_valid_next;
  frx_pkg::frx_out_t       out_data_next;

  // ring memory
  logic                    ram_we;
  logic [PW-1:0]           ram_waddr;
  logic [7:0]              ram_wdata;
  logic [PW-1:0]           ram_raddr;
  logic [PW-1:0]           raddr_q;
  logic [7:0]              ram_rdata;

  frx_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared conditions
  // ---------------------------------------------------------------------------
  logic       in_acc;
  logic       poll_acc;
  logic       write_acc;
  logic [7:0] slot_byte;     // slot read last cycle; never-written or consumed reads empty
  logic       overtaken;
  logic       scan_more;     // reader still more than half the rewind behind
  logic       is_header;
  logic       frame_last;
  logic       frame_stop;    // reader within half a ring of writer; ends the scan after a frame
  logic       out_free;
  logic [PW-1:0] rewind_pt;
  logic [PW:0]   rewind_diff;
  logic [PW:0]   rewind_wrap;

  assign in_stall  = (state != frx_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign poll_acc  = in_acc && (in_data.op == frx_pkg::OP_POLL);
  assign write_acc = in_acc && (in_data.op == frx_pkg::OP_WRITE);

  assign slot_byte = slot_valid[raddr_q] ? ram_rdata : frx_pkg::EMPTY_SLOT;
  assign overtaken = (slot_byte != frx_pkg::EMPTY_SLOT);

  // compared at 9 bits so that half the rewind never truncates on a small ring
  assign scan_more  = 9'(gap(wp, rd)) > 9'(rewind_distance[5:1]);
  assign is_header  = {1'b0, slot_byte} ==
                      ({1'b0, frx_pkg::HEADER_BASE} + {6'b0, node_id});
  assign frame_last = (cnt == LAST_BYTE);
  assign frame_stop = {1'b0, gap(wp, rd)} < HALF_DEPTH;
  assign out_free   = !out_valid || !out_stall;

  assign rewind_diff = {1'b0, wp} - {1'b0, rewind_back};
  assign rewind_wrap = rewind_diff + DEPTH_EXT;
  assign rewind_pt   = rewind_diff[PW] ? rewind_wrap[PW-1:0] : rewind_diff[PW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      frx_pkg::ST_IDLE: begin
        if (poll_acc) begin
          state_next = frx_pkg::ST_DECIDE;
        end
      end
      frx_pkg::ST_DECIDE: begin
        state_next = frx_pkg::ST_CHECK;
      end
      frx_pkg::ST_CHECK: begin
        state_next = scan_more ? frx_pkg::ST_SCAN : frx_pkg::ST_FINISH;
      end
      frx_pkg::ST_SCAN: begin
        state_next = is_header ? frx_pkg::ST_FRAME : frx_pkg::ST_CHECK;
      end
      frx_pkg::ST_FRAME: begin
        if (frame_last) begin
          state_next = frame_stop ? frx_pkg::ST_FINISH : frx_pkg::ST_CHECK;
        end
      end
      frx_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = frx_pkg::ST_IDLE;
        end
      end
      default: state_next = frx_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: datapath and memory controls
  // ---------------------------------------------------------------------------
  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    prior_wp_next   = prior_wp;
    rd_next         = rd;
    cnt_next        = cnt;
    held_next       = held;
    stalls_next     = stalls;
    overruns_next   = overruns;
    slot_valid_next = slot_valid;
    out_valid_next  = out_valid && out_stall;
    out_data_next   = out_data;
    ram_we          = 1'b0;
    ram_waddr       = wp;
    ram_wdata       = in_data.rx_byte;
    ram_raddr       = rd;

    unique case (state)
      frx_pkg::ST_IDLE: begin
        // a poll first looks at the read slot, or the slot past the writer
        // when the reader has caught up
        ram_raddr = (wp != rp) ? rp : next_pos(wp);
        if (write_acc) begin
          ram_we              = 1'b1;
          slot_valid_next[wp] = 1'b1;
          wp_next             = next_pos(wp);
        end
      end
      frx_pkg::ST_DECIDE: begin
        rd_next = overtaken ? rewind_pt : rp;
        if (overtaken) begin
          overruns_next = frx_pkg::sat_inc(overruns);
        end else if ((wp != rp) && (wp != prior_wp)) begin
          stalls_next = '0;
        end else begin
          stalls_next = frx_pkg::sat_inc(stalls);
        end
      end
      frx_pkg::ST_CHECK: begin
        if (scan_more) begin
          rd_next   = next_pos(rd);
          ram_raddr = next_pos(rd);
        end
      end
      frx_pkg::ST_SCAN: begin
        // consume the slot; a header starts a frame at the following slot
        slot_valid_next[rd] = 1'b0;
        if (is_header) begin
          cnt_next  = '0;
          rd_next   = next_pos(rd);
          ram_raddr = next_pos(rd);
        end
      end
      frx_pkg::ST_FRAME: begin
        slot_valid_next[rd] = 1'b0;
        if (cnt == '0) begin
          held_next[7:0] = slot_byte;
        end else if (cnt == FW'(1)) begin
          held_next[15:8] = slot_byte;
        end
        if (!frame_last) begin
          cnt_next  = cnt + 1'b1;
          rd_next   = next_pos(rd);
          ram_raddr = next_pos(rd);
        end
      end
      frx_pkg::ST_FINISH: begin
        rp_next       = rd;
        prior_wp_next = wp;
        if (out_free) begin
          out_valid_next              = 1'b1;
          out_data_next.payload       = held;
          out_data_next.stall_count   = stalls;
          out_data_next.overrun_count = overruns;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= frx_pkg::ST_IDLE;
      node_id         <= frx_pkg::NODE_ID_RESET;
      rewind_distance <= frx_pkg::REWIND_RESET;
      rewind_back     <= BACK_RESET;
      wp              <= '0;
      rp              <= '0;
      prior_wp        <= '0;
      rd              <= '0;
      cnt             <= '0;
      held            <= frx_pkg::PAYLOAD_RESET;
      stalls          <= '0;
      overruns        <= '0;
      slot_valid      <= '0;
      out_valid       <= 1'b0;
    end else begin
      state      <= state_next;
      wp         <= wp_next;
      rp         <= rp_next;
      prior_wp   <= prior_wp_next;
      rd         <= rd_next;
      cnt        <= cnt_next;
      held       <= held_next;
      stalls     <= stalls_next;
      overruns   <= overruns_next;
      slot_valid <= slot_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          frx_pkg::REG_NODE_ID: begin
            node_id <= cfg_data[2:0];
          end
          frx_pkg::REG_REWIND: begin
            rewind_distance <= cfg_data;
            rewind_back     <= wrap_back(cfg_data);
          end
          default: ;
        endcase
      end
    end
  end

  // result payload and read address tag carry no reset
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    raddr_q  <= ram_raddr;
  end

endmodule

@@ sv/frx_checker.sv @@
// Port-level checker for the ring frame extractor, bound to the top level.
`timescale 1ns / 1ps
module frx_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input frx_pkg::frx_in_t               in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input frx_pkg::frx_out_t              out_data,
  input logic                           cfg_wr_en,
  input logic [frx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [frx_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [15:0] last_overruns;
  logic        cfg_seen;

  // overrun count of the last delivered beat
  always_ff @(posedge clk) begin
    if (rst) begin
      last_overruns <= '0;
    end else if (out_valid && !out_stall) begin
      last_overruns <= out_data.overrun_count;
    end
  end

  assign cfg_seen = cfg_wr_en && (cfg_index == frx_pkg::REG_NODE_ID ||
                                  cfg_index == frx_pkg::REG_REWIND) && (cfg_data == cfg_data);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // an accepted poll makes the block busy in the following cycle
  a_poll_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.op == frx_pkg::OP_POLL |=> in_stall)
    else $error("poll did not occupy the sequencer");

  // counters saturate at the limit
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.stall_count <= frx_pkg::COUNT_LIMIT &&
                  out_data.overrun_count <= frx_pkg::COUNT_LIMIT)
    else $error("counter beyond saturation limit");

  // overrun count never goes back between delivered beats
  a_overrun_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |-> out_data.overrun_count >= last_overruns)
    else $error("overrun count decreased");

  // reset empties the output register; config writes do not create results
  a_rst_out: assert property (@(posedge clk)
    rst || (cfg_seen && !out_valid && !in_valid) |=> !out_valid || !$past(rst) && $past(in_stall))
    else $error("result beat appeared without a poll");

endmodule

bind ring_frame_extractor frx_checker u_frx_checker (.*);
